>>> design/mbdfc_pkg.sv
// Shared types, constants and register codes for the MPPT buck duty and fan controller.
// No dependencies; every other design file imports this package.
package mbdfc_pkg;

  // Field widths
  localparam int ADC_W    = 10;
  localparam int VIN_W    = 13;
  localparam int VOUT_W   = 12;
  localparam int IOUT_W   = 10;
  localparam int SP_W     = 13;
  localparam int TGT_W    = 12;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 16;
  localparam int BTN_W    = 2;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 13;
  localparam int DUTY_O_W = 10;

  // Parameter defaults
  localparam int DUTY_MAX_DEF = 1023;
  localparam int ADC_BITS_DEF = 10;

  // Q10 scale factors and current sensor offset
  localparam int VIN_K       = 4903;
  localparam int VOUT_K      = 1879;
  localparam int IOUT_K      = 317;
  localparam int IOUT_OFFSET = 578;

  // Reset values
  localparam int DUTY_RESET = 1023;
  localparam logic [BYTE_W-1:0] FAN_RESET       = 8'd60;
  localparam logic [BYTE_W-1:0] SLOW_CNT_RESET  = 8'd200;
  localparam logic [SP_W-1:0]   SP_RESET_DEF    = 13'd3144;
  localparam logic [SP_W-1:0]   SP_MIN_DEF      = 13'd2800;
  localparam logic [SP_W-1:0]   SP_MAX_DEF      = 13'd3400;
  localparam logic [BYTE_W-1:0] SP_STEP_DEF     = 8'd10;
  localparam logic [BYTE_W-1:0] FAST_PERIOD_DEF = 8'd12;
  localparam logic [BYTE_W-1:0] SLOW_PERIOD_DEF = 8'd21;
  localparam logic [BYTE_W-1:0] FAN_FAULT_DEF   = 8'd55;
  localparam logic [BYTE_W-1:0] FAN_THRESH_DEF  = 8'd20;

  // Fan target offset and ceiling
  localparam logic [IOUT_W-1:0] FAN_WANT_OFS = 10'd10;
  localparam logic [BYTE_W-1:0] FAN_TOP      = 8'd255;
  localparam logic [SP_W-1:0]   SP_TOP       = 13'd8191;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_SP_RESET    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_SP_MIN      = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SP_MAX      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_SP_STEP     = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FAST_PERIOD = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_SLOW_PERIOD = 3'd5;
  localparam logic [CIDX_W-1:0] CFG_FAN_FAULT   = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_FAN_THRESH  = 3'd7;

  // Button codes
  localparam logic [BTN_W-1:0] BTN_NONE  = 2'd0;
  localparam logic [BTN_W-1:0] BTN_UP    = 2'd1;
  localparam logic [BTN_W-1:0] BTN_DOWN  = 2'd2;
  localparam logic [BTN_W-1:0] BTN_ENTER = 2'd3;

  // Scaled measurements handed from the scaler to the control logic
  typedef struct packed {
    logic [VIN_W-1:0]  vin_cv;
    logic [VOUT_W-1:0] vout_cv;
    logic [IOUT_W-1:0] iout_da;
  } scaled_t;

endpackage

>>> design/mbdfc_sample_if.sv
// Input channel of the controller: one control-pass word of raw samples and flags.
// Depends on mbdfc_pkg.
interface mbdfc_sample_if import mbdfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADC_W-1:0]  adc_vin;
  logic [ADC_W-1:0]  adc_vout;
  logic [ADC_W-1:0]  adc_iout;
  logic              fault_start;
  logic              fault_after_reset;
  logic [BTN_W-1:0]  button;
  logic              tracking_mode;
  logic [TGT_W-1:0]  vout_target;

  modport source (output valid, adc_vin, adc_vout, adc_iout, fault_start,
                  fault_after_reset, button, tracking_mode, vout_target,
                  input ready);
  modport sink   (input valid, adc_vin, adc_vout, adc_iout, fault_start,
                  fault_after_reset, button, tracking_mode, vout_target,
                  output ready);
endinterface

>>> design/mbdfc_result_if.sv
// Output channel of the controller: one result word per control pass.
// Depends on mbdfc_pkg.
interface mbdfc_result_if import mbdfc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DUTY_O_W-1:0] buck_duty;
  logic [BYTE_W-1:0]   fan_duty;
  logic [SP_W-1:0]     setpoint;
  logic [VIN_W-1:0]    vin_cv;
  logic [VOUT_W-1:0]   vout_cv;
  logic [IOUT_W-1:0]   iout_da;
  logic [CNT_W-1:0]    fault_events;
  logic [CNT_W-1:0]    fault_stuck_events;
  logic                pwm_update;
  logic                slow_tick;
  logic                display_reinit;

  modport source (output valid, buck_duty, fan_duty, setpoint, vin_cv, vout_cv,
                  iout_da, fault_events, fault_stuck_events, pwm_update,
                  slow_tick, display_reinit, input ready);
  modport sink   (input valid, buck_duty, fan_duty, setpoint, vin_cv, vout_cv,
                  iout_da, fault_events, fault_stuck_events, pwm_update,
                  slow_tick, display_reinit, output ready);
endinterface

>>> design/mbdfc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on mbdfc_pkg.
interface mbdfc_cfg_if import mbdfc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/mbdfc_scale.sv
// Converts raw converter samples to centivolts and deciamps with Q10 constants.
// Depends on mbdfc_pkg.
module mbdfc_scale import mbdfc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic [ADC_W-1:0] adc_vin,
  input  logic [ADC_W-1:0] adc_vout,
  input  logic [ADC_W-1:0] adc_iout,
  output scaled_t          scaled
);

  // Only the low ADC_BITS bits of each sample are meaningful
  localparam logic [ADC_W-1:0] ADC_MASK =
      (ADC_BITS >= ADC_W) ? {ADC_W{1'b1}} : ADC_W'((1 << ADC_BITS) - 1);

  localparam int PROD_W = ADC_W + 13;

  logic [ADC_W-1:0]  a_vin, a_vout, a_iout;
  logic [ADC_W-1:0]  i_diff;
  logic [PROD_W-1:0] vin_prod, vout_prod, iout_prod;
  logic [PROD_W-11:0] vin_sh, vout_sh, iout_sh;

  assign a_vin  = adc_vin  & ADC_MASK;
  assign a_vout = adc_vout & ADC_MASK;
  assign a_iout = adc_iout & ADC_MASK;
  assign i_diff = a_iout - ADC_W'(IOUT_OFFSET);

  // Constant multiplies, then drop the Q10 fraction
  assign vin_prod  = PROD_W'(a_vin)  * PROD_W'(VIN_K);
  assign vout_prod = PROD_W'(a_vout) * PROD_W'(VOUT_K);
  assign iout_prod = PROD_W'(i_diff) * PROD_W'(IOUT_K);
  assign vin_sh    = vin_prod[PROD_W-1:10];
  assign vout_sh   = vout_prod[PROD_W-1:10];
  assign iout_sh   = iout_prod[PROD_W-1:10];

  // Saturate to the field widths; current floors at zero below the offset
  always_comb begin
    scaled.vin_cv  = (vin_sh > (PROD_W-10)'({VIN_W{1'b1}})) ? {VIN_W{1'b1}}
                                                            : vin_sh[VIN_W-1:0];
    scaled.vout_cv = (vout_sh > (PROD_W-10)'({VOUT_W{1'b1}})) ? {VOUT_W{1'b1}}
                                                              : vout_sh[VOUT_W-1:0];
    if (a_iout > ADC_W'(IOUT_OFFSET)) begin
      scaled.iout_da = (iout_sh > (PROD_W-10)'({IOUT_W{1'b1}})) ? {IOUT_W{1'b1}}
                                                                : iout_sh[IOUT_W-1:0];
    end else begin
      scaled.iout_da = '0;
    end
  end

endmodule

>>> design/mppt_buck_duty_and_fan_controller.sv
// Top level of the MPPT buck duty and fan controller: input register, control pass, result register.
// Depends on mbdfc_pkg, the three channel interfaces and mbdfc_scale.
//
//   channel   dir  carries
//   samples   in   raw samples, fault flags, button, mode, output target
//   results   out  duties, setpoint, scaled values, fault counts, tick flags
//   cfg       in   register index and write data, always ready
//
// Each word passes through the input register and then the result register,
// one word per cycle sustained while results.ready is high. The whole
// control pass (scale multiply, compares, duty, setpoint, fan) runs between
// those two registers. A stalled result holds the input register; samples.ready
// drops only when both registers are full and results.ready is low.
// rst is synchronous; it resets configuration, control state and valid flags, not the data registers.
module mppt_buck_duty_and_fan_controller import mbdfc_pkg::*; #(
  parameter int DUTY_MAX = DUTY_MAX_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input logic            clk,
  input logic            rst,
  mbdfc_sample_if.sink   samples,
  mbdfc_result_if.source results,
  mbdfc_cfg_if.sink      cfg
);

  // Duty register must hold both DUTY_MAX and the reset value
  localparam int DUTY_TOP = (DUTY_MAX > DUTY_RESET) ? DUTY_MAX : DUTY_RESET;
  localparam int DUTY_W   = $clog2(DUTY_TOP + 1);
  localparam logic [DUTY_W-1:0] DUTY_LIM = DUTY_W'(DUTY_MAX);

  // Configuration registers
  logic [SP_W-1:0]   sp_reset, sp_min, sp_max;
  logic [BYTE_W-1:0] sp_step, fast_period, slow_period, fan_fault_duty, fan_thresh;

  // Input register
  logic              s1_valid;
  logic [ADC_W-1:0]  s1_vin, s1_vout, s1_iout;
  logic              s1_fstart, s1_fafter, s1_track;
  logic [BTN_W-1:0]  s1_button;
  logic [TGT_W-1:0]  s1_target;

  // Control state
  logic [DUTY_W-1:0] duty_reg, duty_next;
  logic [BYTE_W-1:0] fan_reg, fan_next;
  logic [SP_W-1:0]   setpoint_reg, setpoint_next;
  logic [BYTE_W-1:0] fast_count, fast_count_next;
  logic [BYTE_W-1:0] slow_count, slow_count_next;
  logic [CNT_W-1:0]  fault_counter, fault_counter_next;
  logic [CNT_W-1:0]  stuck_counter, stuck_counter_next;

  // Result register
  logic              o_valid;
  logic              fast, slow, reinit;
  logic              o_fast, o_slow, o_reinit;
  scaled_t           scaled, o_scaled;

  logic              advance;
  logic              climb;
  logic [BYTE_W-1:0] slow_mid;
  logic [SP_W:0]     sp_sum;
  logic [IOUT_W-1:0] fan_want;

  assign advance       = s1_valid && (!o_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign cfg.ready     = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sp_reset       <= SP_RESET_DEF;
      sp_min         <= SP_MIN_DEF;
      sp_max         <= SP_MAX_DEF;
      sp_step        <= SP_STEP_DEF;
      fast_period    <= FAST_PERIOD_DEF;
      slow_period    <= SLOW_PERIOD_DEF;
      fan_fault_duty <= FAN_FAULT_DEF;
      fan_thresh     <= FAN_THRESH_DEF;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SP_RESET:    sp_reset       <= cfg.data;
        CFG_SP_MIN:      sp_min         <= cfg.data;
        CFG_SP_MAX:      sp_max         <= cfg.data;
        CFG_SP_STEP:     sp_step        <= cfg.data[BYTE_W-1:0];
        CFG_FAST_PERIOD: fast_period    <= cfg.data[BYTE_W-1:0];
        CFG_SLOW_PERIOD: slow_period    <= cfg.data[BYTE_W-1:0];
        CFG_FAN_FAULT:   fan_fault_duty <= cfg.data[BYTE_W-1:0];
        CFG_FAN_THRESH:  fan_thresh     <= cfg.data[BYTE_W-1:0];
        default:         ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_vin    <= samples.adc_vin;
      s1_vout   <= samples.adc_vout;
      s1_iout   <= samples.adc_iout;
      s1_fstart <= samples.fault_start;
      s1_fafter <= samples.fault_after_reset;
      s1_button <= samples.button;
      s1_track  <= samples.tracking_mode;
      s1_target <= samples.vout_target;
    end
  end

  mbdfc_scale #(
    .ADC_BITS (ADC_BITS)
  ) u_scale (
    .adc_vin  (s1_vin),
    .adc_vout (s1_vout),
    .adc_iout (s1_iout),
    .scaled   (scaled)
  );

  // Fault counters wrap
  assign fault_counter_next = s1_fstart ? fault_counter + 1'b1 : fault_counter;
  assign stuck_counter_next = s1_fafter ? stuck_counter + 1'b1 : stuck_counter;

  // Fast tick: duty step, setpoint buttons, display reinit
  assign fast  = (fast_count >= fast_period);
  assign climb = s1_track ? (scaled.vin_cv < setpoint_reg)
                          : (TGT_W'(scaled.vout_cv) > s1_target);
  assign sp_sum = {1'b0, setpoint_reg} + (SP_W+1)'(sp_step);

  always_comb begin
    duty_next     = duty_reg;
    setpoint_next = setpoint_reg;
    reinit        = 1'b0;
    if (fast) begin
      if (climb) begin
        if (duty_reg < DUTY_LIM) duty_next = duty_reg + 1'b1;
      end else if (duty_reg != '0) begin
        duty_next = duty_reg - 1'b1;
      end
      unique case (s1_button)
        BTN_DOWN: begin
          if (setpoint_reg > sp_min) begin
            setpoint_next = (setpoint_reg > SP_W'(sp_step))
                            ? setpoint_reg - SP_W'(sp_step) : '0;
          end
        end
        BTN_UP: begin
          if (setpoint_reg < sp_max) begin
            setpoint_next = sp_sum[SP_W] ? SP_TOP : sp_sum[SP_W-1:0];
          end
        end
        BTN_ENTER: reinit = 1'b1;
        BTN_NONE:  ;
        default:   ;
      endcase
    end
  end

  assign fast_count_next = fast ? BYTE_W'(1) : fast_count + 1'b1;

  // Slow tick: fan fault duty, off at low current, else slew toward half the current plus an offset
  assign slow_mid        = fast ? slow_count + 1'b1 : slow_count;
  assign slow            = (slow_mid >= slow_period);
  assign slow_count_next = slow ? '0 : slow_mid;
  assign fan_want        = (scaled.iout_da >> 1) + FAN_WANT_OFS;

  always_comb begin
    fan_next = fan_reg;
    if (slow) begin
      if (s1_fafter) begin
        fan_next = fan_fault_duty;
      end else if (scaled.iout_da > IOUT_W'(fan_thresh)) begin
        if (fan_want > IOUT_W'(fan_reg)) begin
          if (fan_reg != FAN_TOP) fan_next = fan_reg + 1'b1;
        end else if (fan_reg != '0) begin
          fan_next = fan_reg - 1'b1;
        end
      end else begin
        fan_next = '0;
      end
    end
  end

  // Control state commits as the word moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_reg      <= DUTY_W'(DUTY_RESET);
      fan_reg       <= FAN_RESET;
      setpoint_reg  <= SP_RESET_DEF;
      fast_count    <= '0;
      slow_count    <= SLOW_CNT_RESET;
      fault_counter <= '0;
      stuck_counter <= '0;
    end else if (advance) begin
      duty_reg      <= duty_next;
      fan_reg       <= fan_next;
      setpoint_reg  <= setpoint_next;
      fast_count    <= fast_count_next;
      slow_count    <= slow_count_next;
      fault_counter <= fault_counter_next;
      stuck_counter <= stuck_counter_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_scaled <= scaled;
      o_fast   <= fast;
      o_slow   <= slow;
      o_reinit <= reinit;
    end
  end

  assign results.valid              = o_valid;
  assign results.buck_duty          = duty_reg[DUTY_O_W-1:0];
  assign results.fan_duty           = fan_reg;
  assign results.setpoint           = setpoint_reg;
  assign results.vin_cv             = o_scaled.vin_cv;
  assign results.vout_cv            = o_scaled.vout_cv;
  assign results.iout_da            = o_scaled.iout_da;
  assign results.fault_events       = fault_counter;
  assign results.fault_stuck_events = stuck_counter;
  assign results.pwm_update         = o_fast;
  assign results.slow_tick          = o_slow;
  assign results.display_reinit     = o_reinit;

`ifndef SYNTHESIS
  // State moves only when a word is processed
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(duty_reg) && $stable(fan_reg) && $stable(setpoint_reg)
                 && $stable(fast_count) && $stable(slow_count))
    else $error("control state changed without a processed word");

  // A fast tick moves the duty by one unless it sits at a limit
  a_duty_step: assert property (@(posedge clk) disable iff (rst)
    advance && fast |=> (duty_reg != $past(duty_reg)) || ($past(duty_reg) == '0)
                        || ($past(duty_reg) >= DUTY_LIM))
    else $error("buck duty did not step on a fast tick");

  // Fast counter never rests at zero after a processed word
  a_fast_count: assert property (@(posedge clk) disable iff (rst)
    advance |=> fast_count != '0)
    else $error("fast counter at zero after a word");

  // Slow tick clears the slow counter
  a_slow_clear: assert property (@(posedge clk) disable iff (rst)
    advance && slow |=> slow_count == '0)
    else $error("slow counter not cleared on slow tick");

  // A result waiting on the sink is not dropped
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    o_valid && !results.ready |=> o_valid)
    else $error("stalled result lost");
`endif

endmodule
